FILE: rtl/grid_manhattan_distance_map_unit_macros.svh
// ---------------------------------------------------------------------------
// grid_manhattan_distance_map_unit macros
// Assertion helpers used by the gmd_dp datapath of the distance map unit.
// ---------------------------------------------------------------------------
`ifndef GRID_MANHATTAN_DISTANCE_MAP_UNIT_MACROS_SVH
`define GRID_MANHATTAN_DISTANCE_MAP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define GMD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("gmd assertion failed");
`define GMD_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("gmd forbidden condition");
`else
`define GMD_ASSERT(lbl, clk, rstn, prop)
`define GMD_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

FILE: rtl/gmd_pkg.sv
// ---------------------------------------------------------------------------
// gmd_pkg
// Types and constants of the grid Manhattan distance map unit.
// ---------------------------------------------------------------------------
`default_nettype none
package gmd_pkg;

	localparam int CMP_W = 16;
	localparam int DIST_W = 10;
	localparam int WAVE_W = 9;
	localparam int OCC_W = 8;
	localparam int POS_W = 11;
	localparam int CFG_W = 9;
	localparam int IDX_W = 1;

	localparam logic signed [OCC_W-1:0] OCC_THRESH = 8'sd50;
	localparam logic signed [OCC_W-1:0] OCC_UNKNOWN = -8'sd1;
	localparam logic [DIST_W-1:0] DIST_NONE = 10'h3FF;
	localparam logic [WAVE_W-1:0] DIST_SAT = 9'd511;

	localparam logic [IDX_W-1:0] REG_MAP_WIDTH = 1'b0;
	localparam logic [IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_TAIL,
		ST_POP,
		ST_POP_WAIT,
		ST_NB_RD,
		ST_NB_WAIT,
		ST_DONE,
		ST_Q_DATA
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_start;
		logic scan_rd;
		logic pop_rd;
		logic pop_latch;
		logic nb_rd;
		logic nb_next;
		logic nb_wr;
		logic load_build;
		logic load_query;
	} gmd_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic [1:0] in_cmd;
		logic size_zero;
		logic scan_last;
		logic queue_empty;
		logic interior;
		logic nb_free;
		logic nb_last;
		logic out_free;
	} gmd_status_t;

endpackage
`default_nettype wire

FILE: rtl/gmd_ram.sv
// ---------------------------------------------------------------------------
// gmd_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module gmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/gmd_ctrl.sv
// ---------------------------------------------------------------------------
// gmd_ctrl
// Sequencer for cell writes, queries and the wavefront build.
// ---------------------------------------------------------------------------
`default_nettype none
module gmd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gmd_pkg::gmd_status_t sts,
	output logic                     s_tready,
	output gmd_pkg::gmd_cmd_t         cmd
);
	import gmd_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) begin
					unique case (sts.in_cmd)
						CMD_BUILD: state_nx = sts.size_zero ? ST_POP : ST_SCAN;
						CMD_QUERY: state_nx = ST_Q_DATA;
						default:   state_nx = ST_IDLE;
					endcase
				end
			end
			ST_SCAN:      if (sts.scan_last) state_nx = ST_SCAN_TAIL;
			ST_SCAN_TAIL: state_nx = ST_POP;
			ST_POP:       state_nx = sts.queue_empty ? ST_DONE : ST_POP_WAIT;
			ST_POP_WAIT:  state_nx = sts.interior ? ST_NB_RD : ST_POP;
			ST_NB_RD:     state_nx = ST_NB_WAIT;
			ST_NB_WAIT:   state_nx = sts.nb_last ? ST_POP : ST_NB_RD;
			ST_DONE:      if (sts.out_free) state_nx = ST_IDLE;
			ST_Q_DATA:    if (sts.out_free) state_nx = ST_IDLE;
			default:      state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.accept = sts.in_valid;
				cmd.scan_start = sts.in_valid && (sts.in_cmd == CMD_BUILD);
			end
			ST_SCAN:     cmd.scan_rd = 1'b1;
			ST_POP:      cmd.pop_rd = !sts.queue_empty;
			ST_POP_WAIT: cmd.pop_latch = 1'b1;
			ST_NB_RD:    cmd.nb_rd = 1'b1;
			ST_NB_WAIT: begin
				cmd.nb_next = 1'b1;
				cmd.nb_wr = sts.nb_free;
			end
			ST_DONE:     cmd.load_build = sts.out_free;
			ST_Q_DATA:   cmd.load_query = sts.out_free;
			default:     cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/gmd_dp.sv
// ---------------------------------------------------------------------------
// gmd_dp
// Datapath: grid stores, wave queue, scan and neighbor counters, result reg.
// ---------------------------------------------------------------------------
`default_nettype none
`include "grid_manhattan_distance_map_unit_macros.svh"
module gmd_dp #(
	parameter int MAX_SIDE = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [8:0]           cfg_wdata,
	input  wire logic                 s_tvalid,
	input  wire logic [31:0]          s_tdata,
	input  wire logic [1:0]           s_tuser,
	input  wire logic                 m_tready,
	output logic                      m_tvalid,
	output logic [15:0]               m_tdata,
	output logic [0:0]                m_tuser,
	input  wire gmd_pkg::gmd_cmd_t    cmd,
	output gmd_pkg::gmd_status_t      sts
);
	import gmd_pkg::*;

	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int AW = $clog2(CELLS);
	localparam int CW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int QW = WAVE_W + 2 * CW;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] y,
			input logic [CW-1:0] x);
		return AW'(y) * AW'(MAX_SIDE) + AW'(x);
	endfunction

	function automatic logic [CMP_W-1:0] side(input logic [CFG_W-1:0] r);
		logic [CMP_W-1:0] v;
		v = CMP_W'(r);
		return (v > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE) : v;
	endfunction

	logic [CFG_W-1:0] map_width_q, map_height_q;
	logic [SW-1:0]    built_w_q, built_h_q;
	logic             built_q;

	logic signed [POS_W-1:0] pos_x, pos_y;
	logic signed [OCC_W-1:0] occ_in;
	logic [CMP_W-1:0]        px16, py16, bw16, bh16;
	logic                    wr_in_range, q_in_range;
	logic [AW-1:0]           in_addr;

	logic [CW-1:0] scan_x_q, scan_y_q, scan_x_s1, scan_y_s1;
	logic          scan_v_s1;

	logic [AW:0]   head_q, tail_q;
	logic [CW-1:0] cx_q, cy_q, nbx, nby;
	logic [WAVE_W-1:0] d_q, nd;
	logic [1:0]    k_q;
	logic [AW-1:0] nb_addr;

	logic              occ_we, occ_re;
	logic [AW-1:0]     occ_raddr;
	logic [OCC_W-1:0]  occ_rdata;
	logic              dist_we, dist_re;
	logic [AW-1:0]     dist_waddr, dist_raddr;
	logic [DIST_W-1:0] dist_wdata, dist_rdata;
	logic              q_we, scan_push;
	logic [QW-1:0]     q_wdata, q_rdata;
	logic [CW-1:0]     qx, qy;
	logic signed [OCC_W-1:0] occ_v;

	logic              q_ok_s1;
	logic              out_valid_q, out_kind_q;
	logic [14:0]       out_data_q;
	logic              out_free;

	assign pos_x  = s_tdata[10:0];
	assign pos_y  = s_tdata[21:11];
	assign occ_in = s_tdata[29:22];
	assign px16 = CMP_W'(pos_x);
	assign py16 = CMP_W'(pos_y);
	assign bw16 = CMP_W'(built_w_q);
	assign bh16 = CMP_W'(built_h_q);
	assign in_addr = cell_addr(CW'(py16), CW'(px16));

	assign wr_in_range = !pos_x[POS_W-1] && !pos_y[POS_W-1] &&
		(px16 < side(map_width_q)) && (py16 < side(map_height_q));
	assign q_in_range = built_q && !pos_x[POS_W-1] && !pos_y[POS_W-1] &&
		(px16 < bw16) && (py16 < bh16);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= CFG_W'(256);
			map_height_q <= CFG_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:  map_width_q <= cfg_wdata;
				REG_MAP_HEIGHT: map_height_q <= cfg_wdata;
				default:        map_width_q <= map_width_q;
			endcase
		end
	end

	// scan over the grid at build start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q <= 1'b0;
			built_w_q <= '0;
			built_h_q <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_rd;
			if (cmd.scan_start) begin
				built_w_q <= SW'(side(map_width_q));
				built_h_q <= SW'(side(map_height_q));
			end
			if (cmd.load_build) begin
				built_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_x_q <= '0;
			scan_y_q <= '0;
		end else if (cmd.scan_rd) begin
			if (CMP_W'(scan_x_q) + 1'b1 == bw16) begin
				scan_x_q <= '0;
				scan_y_q <= scan_y_q + 1'b1;
			end else begin
				scan_x_q <= scan_x_q + 1'b1;
			end
		end
		scan_x_s1 <= scan_x_q;
		scan_y_s1 <= scan_y_q;
	end

	// wave queue pointers and current cell
	assign scan_push = scan_v_s1 && ($signed(occ_rdata) >= OCC_THRESH);
	assign nd = (d_q == DIST_SAT) ? DIST_SAT : d_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (cmd.scan_start) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.pop_rd) head_q <= head_q + 1'b1;
				if (q_we) tail_q <= tail_q + 1'b1;
			end
		end
	end

	assign qx = q_rdata[CW-1:0];
	assign qy = q_rdata[2*CW-1:CW];

	always_ff @(posedge clk) begin
		if (cmd.pop_latch) begin
			cx_q <= qx;
			cy_q <= qy;
			d_q <= q_rdata[QW-1:2*CW];
			k_q <= '0;
		end else if (cmd.nb_next) begin
			k_q <= k_q + 1'b1;
		end
	end

	// neighbor order: up, left, down, right
	always_comb begin
		nbx = cx_q;
		nby = cy_q;
		case (k_q)
			2'd0: nby = cy_q - 1'b1;
			2'd1: nbx = cx_q - 1'b1;
			2'd2: nby = cy_q + 1'b1;
			default: nbx = cx_q + 1'b1;
		endcase
	end
	assign nb_addr = cell_addr(nby, nbx);

	// memory ports
	assign occ_we = cmd.accept && (s_tuser == CMD_WRITE) && wr_in_range;
	assign occ_re = cmd.scan_rd || (cmd.accept && (s_tuser == CMD_QUERY));
	assign occ_raddr = cmd.scan_rd ? cell_addr(scan_y_q, scan_x_q) : in_addr;

	assign dist_re = cmd.nb_rd || (cmd.accept && (s_tuser == CMD_QUERY));
	assign dist_raddr = cmd.nb_rd ? nb_addr : in_addr;
	assign dist_we = scan_v_s1 || cmd.nb_wr;
	assign dist_waddr = scan_v_s1 ? cell_addr(scan_y_s1, scan_x_s1) : nb_addr;
	assign dist_wdata = scan_v_s1 ? (scan_push ? '0 : DIST_NONE) : DIST_W'(nd);

	assign q_we = scan_push || cmd.nb_wr;
	assign q_wdata = scan_v_s1 ? {WAVE_W'(0), scan_y_s1, scan_x_s1} : {nd, nby, nbx};

	gmd_ram #(.WIDTH(OCC_W), .DEPTH(CELLS)) u_occ (
		.clk(clk), .we(occ_we), .waddr(in_addr), .wdata(occ_in),
		.re(occ_re), .raddr(occ_raddr), .rdata(occ_rdata)
	);

	gmd_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist (
		.clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.re(dist_re), .raddr(dist_raddr), .rdata(dist_rdata)
	);

	gmd_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
		.clk(clk), .we(q_we), .waddr(tail_q[AW-1:0]), .wdata(q_wdata),
		.re(cmd.pop_rd), .raddr(head_q[AW-1:0]), .rdata(q_rdata)
	);

	// query range flag travels with the memory read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			q_ok_s1 <= q_in_range;
		end
	end

	// result register
	assign occ_v = occ_rdata;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_build || cmd.load_query) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_build) begin
			out_kind_q <= 1'b0;
			out_data_q <= {DIST_W'(0), 3'b000, 1'b1, 1'b0};
		end else if (cmd.load_query) begin
			out_kind_q <= 1'b1;
			if (q_ok_s1) begin
				out_data_q <= {dist_rdata,
					(occ_v == OCC_THRESH) || (occ_v == OCC_UNKNOWN),
					occ_v < OCC_THRESH, occ_v > OCC_THRESH, built_q, 1'b1};
			end else begin
				out_data_q <= {DIST_NONE, 3'b000, built_q, 1'b0};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_data_q};
	assign m_tuser = out_kind_q;

	// status to the sequencer
	assign sts.in_valid = s_tvalid;
	assign sts.in_cmd = s_tuser;
	assign sts.size_zero = (side(map_width_q) == '0) || (side(map_height_q) == '0);
	assign sts.scan_last = (CMP_W'(scan_x_q) + 1'b1 == bw16) &&
		(CMP_W'(scan_y_q) + 1'b1 == bh16);
	assign sts.queue_empty = (head_q == tail_q);
	assign sts.interior = (qx != '0) && (CMP_W'(qx) + 1'b1 < bw16) &&
		(qy != '0) && (CMP_W'(qy) + 1'b1 < bh16);
	assign sts.nb_free = (dist_rdata == DIST_NONE);
	assign sts.nb_last = (k_q == 2'd3);
	assign sts.out_free = out_free;

	`GMD_ASSERT(a_head_le_tail, clk, arst_n, head_q <= tail_q)
	`GMD_ASSERT_NEVER(a_queue_overflow, clk, arst_n, q_we && (tail_q >= (AW+1)'(CELLS)))
	`GMD_ASSERT_NEVER(a_occ_port_clash, clk, arst_n, occ_we && cmd.scan_rd)
endmodule
`default_nettype wire

FILE: rtl/grid_manhattan_distance_map_unit.sv
// ---------------------------------------------------------------------------
// grid_manhattan_distance_map_unit
// Occupancy grid store with a brushfire Manhattan distance transform.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tuser: command; tdata: pos_x, pos_y, occupancy
//   m_*      out  tvalid/tready      tuser: answer_kind; tdata: flags, distance
//   cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// A cell write completes on acceptance; a query answer is held by any output stall.
// A build first scans the whole W*H grid, then pops each queued cell and reads
// each neighbor of an interior cell, writing the free ones, one access at a time
// through the single read port of the distance RAM and the wave queue RAM.
// Reset clears control state only; grid contents are not cleared.
// The input stalls while a build or query is running.
// ---------------------------------------------------------------------------
`default_nettype none
module grid_manhattan_distance_map_unit #(
	parameter int MAX_SIDE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [8:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // pos_x[10:0], pos_y[21:11], occupancy[29:22]
	input  wire logic [1:0]  s_tuser,   // command[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // in_range, map_ready, occupied, unoccupied,
	                                    // unknown_cell, distance[14:5]
	output logic [0:0]       m_tuser    // answer_kind
);
	import gmd_pkg::*;

	gmd_cmd_t    cmd;
	gmd_status_t sts;

	gmd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .s_tready(s_tready), .cmd(cmd)
	);

	gmd_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cmd(cmd), .sts(sts)
	);
endmodule
`default_nettype wire
